FILE: hdl/oanht_pkg.sv
// ----------------------------------------------------------------------------
// oanht_pkg
// shared types and codes of the name hash table
// ----------------------------------------------------------------------------
package oanht_pkg;

  localparam int KEY_W    = 10;
  localparam int LETTER_W = 5;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;
  localparam int PROBE_W  = 6;
  localparam logic [KEY_W-1:0] KEY_MAX = 10'd1023;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd4;

  // name job handed from front to back
  typedef struct packed {
    logic             lookup;
    logic             too_long;
    logic [KEY_W-1:0] key;
    logic [6:0]       len;   // letter count, up to MAX_NAME_LETTERS
    logic             bank;  // staging buffer that holds the letters
  } job_t;

endpackage

FILE: hdl/oanht_front.sv
// ----------------------------------------------------------------------------
// oanht_front
// letter staging, key accumulation and job issue
// ----------------------------------------------------------------------------
module oanht_front #(
  parameter int MAX_NAME_LETTERS = 32,
  parameter int LEN_W            = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_operation,
  input  logic [4:0]               in_letter,
  input  logic                     in_last_letter,
  output logic                     job_valid,
  input  logic                     job_ready,
  output oanht_pkg::job_t          job,
  // back side reads staged letters of a bank
  input  logic                     rd_bank,
  input  logic [LEN_W-1:0]         rd_idx,
  output logic [4:0]               rd_letter,
  input  logic                     bank_free
);
  import oanht_pkg::*;

  logic [LETTER_W-1:0] stage_r [2][MAX_NAME_LETTERS];
  logic [LETTER_W-1:0] rd_letter_r;
  logic [KEY_W-1:0]    sum_r, sum_nxt;
  logic [LEN_W:0]      cnt_r, cnt_nxt;
  logic                long_r, long_nxt;
  logic                bank_r;
  logic                job_valid_r;
  job_t                job_r;
  logic [KEY_W:0]      sum_wide;
  logic                acc;

  // hold input while a job waits or the bank is still read by the back end
  assign in_ready  = !job_valid_r && bank_free;
  assign acc       = in_valid && in_ready;
  assign job_valid = job_valid_r;
  assign job       = job_r;
  assign rd_letter = rd_letter_r;

  always_comb begin
    sum_wide = {1'b0, sum_r} + {{(KEY_W+1-LETTER_W){1'b0}}, in_letter};
    sum_nxt  = sum_wide[KEY_W] ? KEY_MAX : sum_wide[KEY_W-1:0];
    long_nxt = long_r;
    cnt_nxt  = cnt_r;
    if (cnt_r < (LEN_W+1)'(MAX_NAME_LETTERS)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else begin
      long_nxt = 1'b1;
    end
  end

  // staging store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (acc && cnt_r < (LEN_W+1)'(MAX_NAME_LETTERS)) begin
      stage_r[bank_r][cnt_r[LEN_W-1:0]] <= in_letter;
    end
    rd_letter_r <= stage_r[rd_bank][rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0; cnt_r <= '0; long_r <= 1'b0; bank_r <= 1'b0;
      job_valid_r <= 1'b0;
    end else begin
      if (job_valid_r && job_ready) job_valid_r <= 1'b0;
      if (acc) begin
        if (in_last_letter) begin
          job_valid_r     <= 1'b1;
          job_r.lookup    <= in_operation;
          job_r.too_long  <= long_nxt;
          job_r.key       <= sum_nxt;
          job_r.len       <= 7'(cnt_nxt);
          job_r.bank      <= bank_r;
          bank_r <= ~bank_r;
          sum_r <= '0; cnt_r <= '0; long_r <= 1'b0;
        end else begin
          sum_r <= sum_nxt; cnt_r <= cnt_nxt; long_r <= long_nxt;
        end
      end
    end
  end

endmodule

FILE: hdl/oanht_back.sv
// ----------------------------------------------------------------------------
// oanht_back
// probe sequencer over the slot table with letter memory
// ----------------------------------------------------------------------------
module oanht_back #(
  parameter int TABLE_SLOTS      = 47,
  parameter int MAX_NAME_LETTERS = 32,
  parameter int STEP_MODULUS     = 10,
  parameter int LEN_W            = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       job_valid,
  output logic                       job_ready,
  input  oanht_pkg::job_t            job,
  output logic                       rd_bank,
  output logic [LEN_W-1:0]           rd_idx,
  input  logic [4:0]                 rd_letter,
  output logic [1:0]                 banks_busy,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_status,
  output logic [5:0]                 out_slot,
  output logic [5:0]                 out_probe_length,
  output logic [9:0]                 out_name_key
);
  import oanht_pkg::*;

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int AW = $clog2(TABLE_SLOTS * MAX_NAME_LETTERS);
  localparam int PW = $clog2(TABLE_SLOTS + 1);
  // reciprocal quotients, exact for any 10-bit key
  localparam int RSH    = 20;
  localparam int PRW    = KEY_W + RSH + 1;
  localparam int HRECIP = (2**RSH + TABLE_SLOTS - 1) / TABLE_SLOTS;
  localparam int SRECIP = (2**RSH + STEP_MODULUS - 1) / STEP_MODULUS;

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_REM, S_PROBE, S_CMP, S_CMPW, S_COPY, S_DONE
  } st_t;

  logic [TABLE_SLOTS-1:0] occ_r;
  logic [6:0]             slen_r  [TABLE_SLOTS];
  logic [6:0]             slen_q_r;
  logic [LETTER_W-1:0]    mem_r   [TABLE_SLOTS*MAX_NAME_LETTERS];
  logic [LETTER_W-1:0]    mem_q_r;

  st_t                st_r;
  job_t               j_r;
  logic [KEY_W-1:0]   hq_r, sq_r;
  logic [PRW-1:0]     hprod, sprod;
  logic [KEY_W-1:0]   hmul, smul;
  logic [SW-1:0]      pos_r, step_r;
  logic [PW-1:0]      prb_r;
  logic [LEN_W:0]     i_r;
  logic               ov_r;
  logic [2:0]         ost_r;
  logic [5:0]         oslot_r, oprb_r;
  logic [9:0]         okey_r;
  logic [AW-1:0]      base;
  logic [SW:0]        pos_sum;
  logic               wr_en;

  assign job_ready = (st_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_status = ost_r;
  assign out_slot = oslot_r;
  assign out_probe_length = oprb_r;
  assign out_name_key = okey_r;
  assign rd_bank = j_r.bank;
  assign rd_idx  = i_r[LEN_W-1:0];
  assign banks_busy[0] = (st_r != S_IDLE) && !j_r.bank;
  assign banks_busy[1] = (st_r != S_IDLE) && j_r.bank;
  assign base    = AW'(pos_r * MAX_NAME_LETTERS);
  assign pos_sum = {1'b0, pos_r} + {1'b0, step_r};
  // staged letters arrive in the cycle after their index is presented
  assign wr_en   = (st_r == S_COPY) && (i_r != '0);
  assign hprod   = PRW'(j_r.key) * PRW'(HRECIP);
  assign sprod   = PRW'(j_r.key) * PRW'(SRECIP);
  assign hmul    = hq_r * KEY_W'(TABLE_SLOTS);
  assign smul    = sq_r * KEY_W'(STEP_MODULUS);

  // letter memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[base + AW'(i_r) - AW'(1)] <= rd_letter;
    mem_q_r <= mem_r[base + AW'(i_r)];
    if (st_r == S_COPY && i_r == '0) slen_r[pos_r] <= j_r.len;
    slen_q_r <= slen_r[pos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; occ_r <= '0; ov_r <= 1'b0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (job_valid && !ov_r) begin
          j_r <= job;
          prb_r <= '0; i_r <= '0;
          st_r <= S_MOD;
        end
        // quotients by reciprocal multiplication
        S_MOD: begin
          hq_r <= hprod[RSH +: KEY_W];
          sq_r <= sprod[RSH +: KEY_W];
          st_r <= S_REM;
        end
        S_REM: begin
          pos_r  <= SW'(j_r.key - hmul);
          step_r <= SW'(j_r.key - smul + 1'b1);
          st_r   <= j_r.too_long ? S_DONE : S_PROBE;
          ost_r  <= ST_TOO_LONG; oslot_r <= '0; oprb_r <= '0;
        end
        S_PROBE: begin
          i_r <= '0;
          if (prb_r == PW'(TABLE_SLOTS)) begin
            ost_r <= j_r.lookup ? ST_NOT_FOUND : ST_FULL;
            oslot_r <= '0; oprb_r <= 6'(prb_r); st_r <= S_DONE;
          end else if (!occ_r[pos_r]) begin
            oprb_r <= 6'(prb_r + 1'b1);
            if (j_r.lookup) begin
              ost_r <= ST_NOT_FOUND; oslot_r <= '0; st_r <= S_DONE;
            end else begin
              ost_r <= ST_INSERTED; oslot_r <= 6'(pos_r); st_r <= S_COPY;
              occ_r[pos_r] <= 1'b1;
            end
          end else if (j_r.lookup) begin
            st_r <= S_CMPW;
          end else begin
            prb_r <= prb_r + 1'b1;
            pos_r <= (pos_sum >= (SW+1)'(TABLE_SLOTS)) ?
                     SW'(pos_sum - (SW+1)'(TABLE_SLOTS)) : pos_sum[SW-1:0];
          end
        end
        // wait state for the registered memory reads
        S_CMPW: st_r <= S_CMP;
        S_CMP: begin
          if (slen_q_r != j_r.len ||
              (7'(i_r) < j_r.len && mem_q_r != rd_letter)) begin
            prb_r <= prb_r + 1'b1; st_r <= S_PROBE;
            pos_r <= (pos_sum >= (SW+1)'(TABLE_SLOTS)) ?
                     SW'(pos_sum - (SW+1)'(TABLE_SLOTS)) : pos_sum[SW-1:0];
          end else if (7'(i_r) >= j_r.len) begin
            ost_r <= ST_FOUND; oslot_r <= 6'(pos_r);
            oprb_r <= 6'(prb_r + 1'b1); st_r <= S_DONE;
          end else begin
            i_r <= i_r + 1'b1; st_r <= S_CMPW;
          end
        end
        S_COPY: begin
          if (7'(i_r) >= j_r.len) st_r <= S_DONE;
          else i_r <= i_r + 1'b1;
        end
        S_DONE: begin
          ov_r <= 1'b1; okey_r <= j_r.key; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/open_addressing_name_hash_table.sv
// ----------------------------------------------------------------------------
// open_addressing_name_hash_table
// names in letter by letter, inserted into or looked up in a probed table
// ----------------------------------------------------------------------------
//  channel | direction | transfer
//  in_     | input     | one letter, operation and last mark
//  out_    | output    | status, slot, probe length and key per name
//
// letters: one transfer per cycle into the staging buffers when not stalled
// after a last letter: hand-over, then home slot and step by quotient and
//   remainder, then probes; a lookup compares the stored length and then the
//   letters of each occupied slot met; an insert copies the letters; then finish
// reset empties the table at once through the occupied flags
// input stalls while a finished name waits; a held result stalls the back end
module open_addressing_name_hash_table #(
  parameter int TABLE_SLOTS      = 47,
  parameter int MAX_NAME_LETTERS = 32,
  parameter int STEP_MODULUS     = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic [4:0] in_letter,
  input  logic       in_last_letter,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [5:0] out_slot,
  output logic [5:0] out_probe_length,
  output logic [9:0] out_name_key
);
  import oanht_pkg::*;

  localparam int LEN_W = $clog2(MAX_NAME_LETTERS);

  job_t             job;
  logic             job_valid, job_ready, rd_bank, front_bank_free;
  logic [LEN_W-1:0] rd_idx;
  logic [4:0]       rd_letter;
  logic [1:0]       banks_busy;

  // front may fill the other staging bank while the back end probes
  assign front_bank_free = !(banks_busy[0] && banks_busy[1]);

  oanht_front #(.MAX_NAME_LETTERS(MAX_NAME_LETTERS), .LEN_W(LEN_W)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation, .in_letter,
    .in_last_letter, .job_valid, .job_ready, .job, .rd_bank, .rd_idx,
    .rd_letter, .bank_free(front_bank_free)
  );

  oanht_back #(.TABLE_SLOTS(TABLE_SLOTS), .MAX_NAME_LETTERS(MAX_NAME_LETTERS),
    .STEP_MODULUS(STEP_MODULUS), .LEN_W(LEN_W)) u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job, .rd_bank, .rd_idx, .rd_letter,
    .banks_busy, .out_valid, .out_ready, .out_status, .out_slot,
    .out_probe_length, .out_name_key
  );

  // a result held back keeps its status
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");

  // too-long results carry no slot and no probes
  a_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_TOO_LONG |-> out_slot == 6'd0 && out_probe_length == 6'd0)
    else $error("too long result malformed");

  // a slot reported is inside the table
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_slot < 6'(TABLE_SLOTS))
    else $error("slot out of range");

endmodule
